### src/cartesian_to_polar_assert.svh
// Assertion macros for the cartesian_to_polar block.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef CARTESIAN_TO_POLAR_ASSERT_SVH
`define CARTESIAN_TO_POLAR_ASSERT_SVH

// Same-cycle implication.
`define C2P_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication after a fixed number of cycles.
`define C2P_ASSERT_LAT(label, ante, lat, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##lat (cons)) else $error(msg);

`endif

### src/c2p_pkg.sv
`timescale 1ns / 1ps

package c2p_pkg;

    // CORDIC datapath: 64-bit x/y, Q.24 angle accumulator
    localparam int CW        = 64;
    localparam int ZW        = 32;
    localparam int ANG_FRAC  = 24;
    localparam int OUT_FRAC  = 13;
    localparam int ANG_W     = 16;
    localparam int MAX_GUARD = 60;

    typedef logic signed [ANG_W-1:0] t_angle;

    localparam logic signed [ZW-1:0] Z_PI        = 32'sd52707179;
    localparam t_angle               ANG_PI      = 16'sd25736;
    localparam t_angle               ANG_HALF_PI = 16'sd12868;
    localparam t_angle               ANG_ZERO    = 16'sd0;

    typedef struct packed {
        logic und;
        logic x_zero;
        logic y_zero;
        logic x_neg;
        logic y_neg;
    } t_flags;

    // atan(2^-i) in Q.24; below 2^-8 the angle equals the shift weight
    function automatic logic signed [ZW-1:0] atan_q24(input int unsigned idx);
        logic signed [ZW-1:0] val;
        val = '0;
        unique case (idx)
            0:       val = 32'sd13176795;
            1:       val = 32'sd7778716;
            2:       val = 32'sd4110060;
            3:       val = 32'sd2086331;
            4:       val = 32'sd1047214;
            5:       val = 32'sd524117;
            6:       val = 32'sd262123;
            7:       val = 32'sd131069;
            8:       val = 32'sd65536;
            default: begin
                if (idx <= ANG_FRAC) begin
                    val = ZW'(1) << (ANG_FRAC - idx);
                end else begin
                    val = '0;
                end
            end
        endcase
        return val;
    endfunction

endpackage

### src/cartesian_to_polar.sv
`timescale 1ns / 1ps
`include "cartesian_to_polar_assert.svh"

// Cartesian to polar converter.
// Input: raise start with i_coord_x / i_coord_y; a point transfers on every edge
// with start high and busy low. busy is always low, so one point can enter
// on every clock.
// Output: o_valid is high for one cycle with o_radius, o_angle and o_undefined.
// The receiver takes each result in that cycle; it has no way to stall.
// o_radius = round(sqrt(x^2 + y^2)), o_angle = atan2(y, x) in Q2.13 radians.
// The origin gives o_undefined = 1 with zero radius and angle.
// Datapath: input register, square / CORDIC setup stage, an unrolled CORDIC /
// square-root stage chain and the output register, in that order; each stage
// does at most one CORDIC micro-rotation and one root bit, both side by side.
// Throughput: one point per cycle, results leave in input order.
// Reset clears only the valid bits; points in flight are dropped and o_valid
// goes low on the next edge.

module cartesian_to_polar
    import c2p_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int ITERATIONS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_coord_x,
    input  logic signed [DATA_WIDTH-1:0] i_coord_y,
    output logic                         o_valid,
    output logic        [DATA_WIDTH-1:0] o_radius,
    output logic signed [ANG_W-1:0]      o_angle,
    output logic                         o_undefined
);

    localparam int DW    = DATA_WIDTH;
    localparam int SQW   = 2 * DATA_WIDTH;
    localparam int NST   = (ITERATIONS > DATA_WIDTH) ? ITERATIONS : DATA_WIDTH;
    localparam int GUARD = MAX_GUARD - DATA_WIDTH;
    localparam int LAT   = NST + 4;

    localparam logic signed [ZW-1:0] Z_RND = ZW'(1) << (ANG_FRAC - OUT_FRAC - 1);

    // input register
    logic                 r_in_vld;
    logic signed [DW-1:0] r_x;
    logic signed [DW-1:0] r_y;

    // square / CORDIC setup stage
    logic                  r_p1_vld;
    logic        [SQW-1:0] r_sqx;
    logic        [SQW-1:0] r_sqy;
    logic signed [CW-1:0]  r_p1_cx;
    logic signed [CW-1:0]  r_p1_cy;
    logic signed [ZW-1:0]  r_p1_z;
    t_flags                r_p1_flg;

    logic signed [SQW-1:0] w_sqx;
    logic signed [SQW-1:0] w_sqy;
    logic signed [CW-1:0]  w_x_ext;
    logic signed [CW-1:0]  w_y_ext;
    logic signed [CW-1:0]  n_p1_cx;
    logic signed [CW-1:0]  n_p1_cy;
    logic signed [ZW-1:0]  n_p1_z;
    t_flags                n_p1_flg;

    // stage chain; index 0 is loaded from the setup stage
    logic                  r_vld  [NST+1];
    logic        [SQW-1:0] r_rem  [NST+1];
    logic        [SQW-1:0] r_root [NST+1];
    logic signed [CW-1:0]  r_cx   [NST+1];
    logic signed [CW-1:0]  r_cy   [NST+1];
    logic signed [ZW-1:0]  r_z    [NST+1];
    t_flags                r_flg  [NST+1];

    logic        [SQW-1:0] n_rem  [NST];
    logic        [SQW-1:0] n_root [NST];
    logic signed [CW-1:0]  n_cx   [NST];
    logic signed [CW-1:0]  n_cy   [NST];
    logic signed [ZW-1:0]  n_z    [NST];

    // output register
    logic                 r_out_vld;
    logic        [DW-1:0] r_radius;
    t_angle               r_angle;
    logic                 r_und;

    logic signed [ZW-1:0] w_zr;
    logic        [DW-1:0] w_root_lo;
    t_angle               w_ang_sat;
    t_angle               n_angle;
    logic        [DW-1:0] n_radius;

    assign busy = 1'b0;

    // ---------------- setup stage ----------------
    assign w_sqx   = SQW'(r_x) * SQW'(r_x);
    assign w_sqy   = SQW'(r_y) * SQW'(r_y);
    assign w_x_ext = CW'(r_x) <<< GUARD;
    assign w_y_ext = CW'(r_y) <<< GUARD;

    always_comb begin
        // left half plane: rotate by pi so the vectoring loop starts in |angle| < pi/2
        if (r_x[DW-1]) begin
            n_p1_cx = -w_x_ext;
            n_p1_cy = -w_y_ext;
            n_p1_z  = r_y[DW-1] ? -Z_PI : Z_PI;
        end else begin
            n_p1_cx = w_x_ext;
            n_p1_cy = w_y_ext;
            n_p1_z  = '0;
        end
        n_p1_flg.x_zero = (r_x == '0);
        n_p1_flg.y_zero = (r_y == '0);
        n_p1_flg.und    = (r_x == '0) && (r_y == '0);
        n_p1_flg.x_neg  = r_x[DW-1];
        n_p1_flg.y_neg  = r_y[DW-1];
    end

    // ---------------- stage chain ----------------
    for (genvar s = 0; s < NST; s++) begin : g_stage
        if (s < DATA_WIDTH) begin : g_sqrt
            localparam logic [SQW-1:0] SQ_BIT = SQW'(1) << (SQW - 2 - 2 * s);
            logic [SQW-1:0] w_trial;
            assign w_trial = r_root[s] + SQ_BIT;
            always_comb begin
                if (r_rem[s] >= w_trial) begin
                    n_rem[s]  = r_rem[s] - w_trial;
                    n_root[s] = (r_root[s] >> 1) + SQ_BIT;
                end else begin
                    n_rem[s]  = r_rem[s];
                    n_root[s] = r_root[s] >> 1;
                end
            end
        end else begin : g_sqrt_pass
            assign n_rem[s]  = r_rem[s];
            assign n_root[s] = r_root[s];
        end

        if (s < ITERATIONS) begin : g_cordic
            localparam logic signed [ZW-1:0] ATAN_S = atan_q24(s);
            logic signed [CW-1:0] w_dx;
            logic signed [CW-1:0] w_dy;
            assign w_dx = r_cy[s] >>> s;
            assign w_dy = r_cx[s] >>> s;
            always_comb begin
                if (!r_cy[s][CW-1]) begin
                    n_cx[s] = r_cx[s] + w_dx;
                    n_cy[s] = r_cy[s] - w_dy;
                    n_z[s]  = r_z[s] + ATAN_S;
                end else begin
                    n_cx[s] = r_cx[s] - w_dx;
                    n_cy[s] = r_cy[s] + w_dy;
                    n_z[s]  = r_z[s] - ATAN_S;
                end
            end
        end else begin : g_cordic_pass
            assign n_cx[s] = r_cx[s];
            assign n_cy[s] = r_cy[s];
            assign n_z[s]  = r_z[s];
        end
    end

    // ---------------- output stage ----------------
    assign w_zr      = (r_z[NST] + Z_RND) >>> (ANG_FRAC - OUT_FRAC);
    assign w_root_lo = r_root[NST][DW-1:0];

    always_comb begin
        if (w_zr > ZW'(ANG_PI)) begin
            w_ang_sat = ANG_PI;
        end else if (w_zr < -ZW'(ANG_PI)) begin
            w_ang_sat = -ANG_PI;
        end else begin
            w_ang_sat = ANG_W'(w_zr);
        end

        priority if (r_flg[NST].und) begin
            n_angle = ANG_ZERO;
        end else if (r_flg[NST].x_zero) begin
            n_angle = r_flg[NST].y_neg ? -ANG_HALF_PI : ANG_HALF_PI;
        end else if (r_flg[NST].y_zero) begin
            n_angle = r_flg[NST].x_neg ? ANG_PI : ANG_ZERO;
        end else begin
            n_angle = w_ang_sat;
        end

        // round to nearest: remainder above the floor root bumps it
        n_radius = (r_rem[NST] > r_root[NST]) ? w_root_lo + DW'(1) : w_root_lo;
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= NST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_in_vld  <= start && !busy;
            r_p1_vld  <= r_in_vld;
            r_vld[0]  <= r_p1_vld;
            for (int k = 0; k < NST; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
            r_out_vld <= r_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_x <= i_coord_x;
            r_y <= i_coord_y;
        end

        r_sqx    <= SQW'(w_sqx);
        r_sqy    <= SQW'(w_sqy);
        r_p1_cx  <= n_p1_cx;
        r_p1_cy  <= n_p1_cy;
        r_p1_z   <= n_p1_z;
        r_p1_flg <= n_p1_flg;

        r_rem[0]  <= r_sqx + r_sqy;
        r_root[0] <= '0;
        r_cx[0]   <= r_p1_cx;
        r_cy[0]   <= r_p1_cy;
        r_z[0]    <= r_p1_z;
        r_flg[0]  <= r_p1_flg;

        for (int k = 0; k < NST; k++) begin
            r_rem[k+1]  <= n_rem[k];
            r_root[k+1] <= n_root[k];
            r_cx[k+1]   <= n_cx[k];
            r_cy[k+1]   <= n_cy[k];
            r_z[k+1]    <= n_z[k];
            r_flg[k+1]  <= r_flg[k];
        end

        r_radius <= n_radius;
        r_angle  <= n_angle;
        r_und    <= r_flg[NST].und;
    end

    assign o_valid     = r_out_vld;
    assign o_radius    = r_radius;
    assign o_angle     = r_angle;
    assign o_undefined = r_und;

    // ---------------- assertions ----------------
    `C2P_ASSERT_LAT(a_latency, start && !busy, LAT, o_valid,
                    "result strobe missing after transfer")
    `C2P_ASSERT_IMP(a_origin_zero, o_valid && o_undefined,
                    (o_radius == '0) && (o_angle == ANG_ZERO), "origin result not zero")
    `C2P_ASSERT_IMP(a_radius_nonzero, o_valid && !o_undefined, o_radius != '0,
                    "zero radius off the origin")
    `C2P_ASSERT_IMP(a_angle_range, o_valid, (o_angle <= ANG_PI) && (o_angle >= -ANG_PI),
                    "angle outside -pi..pi")

endmodule

### sim/tb_cartesian_to_polar.sv
`timescale 1ns / 1ps

module tb_cartesian_to_polar;
    import c2p_pkg::*;

    localparam int PERIOD        = 12;
    localparam int RST_CYCLES    = 10;
    localparam int LATENCY       = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_POINTS = 900;
    localparam int CORDIC_STEPS  = 16;
    localparam int COORD_SHIFT   = 44;

    localparam logic signed [15:0] C_MIN = 16'sh8000;
    localparam logic signed [15:0] C_MAX = 16'sh7FFF;

    localparam longint Z_HALF_TURN = 64'sd52707179;

    // atan(2^-i), Q.24
    localparam longint ARCTAN_Q24 [CORDIC_STEPS] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
    };

    localparam logic signed [15:0] CORNER [6] = '{
        16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF
    };

    typedef struct packed {
        logic [15:0] radius;
        t_angle      angle;
        logic        origin;
    } t_polar;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               typed;
        t_polar             want;
    } t_row;

    localparam int ROWS = 23;

    // axis and origin rows carry their result; the rest go through polar_of
    localparam t_row DIR_TAB [ROWS] = '{
        '{16'sd0,  16'sd0,  1'b1, '{16'd0,     ANG_ZERO,     1'b1}},
        '{16'sd0,  C_MAX,   1'b1, '{16'd32767, ANG_HALF_PI,  1'b0}},
        '{16'sd0,  C_MIN,   1'b1, '{16'd32768, -ANG_HALF_PI, 1'b0}},
        '{C_MAX,   16'sd0,  1'b1, '{16'd32767, ANG_ZERO,     1'b0}},
        '{C_MIN,   16'sd0,  1'b1, '{16'd32768, ANG_PI,       1'b0}},
        '{16'sd0,  16'sd1,  1'b1, '{16'd1,     ANG_HALF_PI,  1'b0}},
        '{16'sd0,  -16'sd1, 1'b1, '{16'd1,     -ANG_HALF_PI, 1'b0}},
        '{16'sd1,  16'sd0,  1'b1, '{16'd1,     ANG_ZERO,     1'b0}},
        '{-16'sd1, 16'sd0,  1'b1, '{16'd1,     ANG_PI,       1'b0}},
        '{C_MIN,   C_MIN,   1'b0, '0},
        '{C_MAX,   C_MAX,   1'b0, '0},
        '{C_MIN,   C_MAX,   1'b0, '0},
        '{C_MAX,   C_MIN,   1'b0, '0},
        '{16'sd1,  16'sd1,  1'b0, '0},
        '{-16'sd1, 16'sd1,  1'b0, '0},
        '{-16'sd1, -16'sd1, 1'b0, '0},
        '{16'sd1,  -16'sd1, 1'b0, '0},
        '{C_MIN,   -16'sd1, 1'b0, '0},
        '{C_MIN,   16'sd1,  1'b0, '0},
        '{16'sd3,  16'sd4,  1'b0, '0},
        '{16'sd2,  16'sd2,  1'b0, '0},
        '{16'sd2,  16'sd1,  1'b0, '0},
        '{C_MAX,   16'sd1,  1'b0, '0}
    };

    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               start     = 1'b0;
    logic signed [15:0] i_coord_x = '0;
    logic signed [15:0] i_coord_y = '0;
    logic               busy;
    logic               o_valid;
    logic [15:0]        o_radius;
    t_angle             o_angle;
    logic               o_undefined;
    logic               xfer;

    t_polar pending_q [$];
    int     errors      = 0;
    int     idle_cycles = 0;

    assign xfer = start && !busy;

    always #(PERIOD / 2) i_clk = ~i_clk;

    cartesian_to_polar #(
        .DATA_WIDTH(16),
        .ITERATIONS(CORDIC_STEPS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .o_valid    (o_valid),
        .o_radius   (o_radius),
        .o_angle    (o_angle),
        .o_undefined(o_undefined)
    );

    function automatic t_polar polar_of(input logic signed [15:0] x,
                                        input logic signed [15:0] y);
        t_polar          res;
        longint          sx, sy, cx, cy, dx, dy, z, q;
        longint unsigned sq, root, cand;
        sx = x;
        sy = y;
        sq = longint'(sx * sx + sy * sy);
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= sq) begin
                root = cand;
            end
        end
        // round up when the leftover exceeds the floor root
        if (sq - root * root > root) begin
            root = root + 1;
        end
        res.radius = root[15:0];
        res.origin = 1'b0;
        if (sx == 0 && sy == 0) begin
            res.angle  = ANG_ZERO;
            res.origin = 1'b1;
        end else if (sx == 0) begin
            res.angle = (sy > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
        end else if (sy == 0) begin
            res.angle = (sx > 0) ? ANG_ZERO : ANG_PI;
        end else begin
            cx = sx <<< COORD_SHIFT;
            cy = sy <<< COORD_SHIFT;
            z  = 0;
            // left half plane: fold over and start from +/- pi
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                z  = (sy >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z  = z + ARCTAN_Q24[i];
                end else begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z  = z - ARCTAN_Q24[i];
                end
            end
            q = (z + 1024) >>> 11;
            if (q > longint'(ANG_PI)) begin
                q = ANG_PI;
            end
            if (q < -longint'(ANG_PI)) begin
                q = -longint'(ANG_PI);
            end
            res.angle = t_angle'(q);
        end
        return res;
    endfunction

    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic typed, input t_polar want);
        start     <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        do @(posedge i_clk); while (!xfer);
        pending_q.push_back(typed ? want : polar_of(x, y));
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_polar want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                $error("o_valid unknown");
                errors = errors + 1;
            end else if (o_valid) begin
                if (pending_q.size() == 0) begin
                    $error("result with no pending point: radius %0d angle %0d",
                           o_radius, o_angle);
                    errors = errors + 1;
                end else begin
                    want = pending_q.pop_front();
                    if (o_radius !== want.radius) begin
                        $error("radius: expected %0d, got %0d", want.radius, o_radius);
                        errors = errors + 1;
                    end
                    if (o_angle !== want.angle) begin
                        $error("angle: expected %0d, got %0d", want.angle, o_angle);
                        errors = errors + 1;
                    end
                    if (o_undefined !== want.origin) begin
                        $error("undefined: expected %0d, got %0d", want.origin,
                               o_undefined);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (xfer || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int                 burst_left;
        int                 mode;
        logic signed [15:0] px, py;
        burst_left = 0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[k]) begin
            if ($urandom_range(0, 3) == 0) begin
                pause($urandom_range(1, 4));
            end
            send_point(DIR_TAB[k].x, DIR_TAB[k].y, DIR_TAB[k].typed, DIR_TAB[k].want);
        end

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                         : $urandom_range(1, 30);
                if ($urandom_range(0, 4) != 0) begin
                    pause($urandom_range(1, 12));
                end
            end
            burst_left = burst_left - 1;
            mode = $urandom_range(0, 9);
            px = 16'($urandom);
            py = 16'($urandom);
            case (mode)
                0: begin
                    if ($urandom_range(0, 1)) begin
                        px = '0;
                    end else begin
                        py = '0;
                    end
                end
                1: begin
                    px = CORNER[$urandom_range(0, 5)];
                    py = CORNER[$urandom_range(0, 5)];
                end
                2: begin
                    px = $signed(16'($urandom_range(0, 16))) - 16'sd8;
                    py = $signed(16'($urandom_range(0, 16))) - 16'sd8;
                end
                default: begin
                end
            endcase
            send_point(px, py, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);

        if (errors == 0 && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### cartesian_to_polar.f
+incdir+src
src/c2p_pkg.sv
src/cartesian_to_polar.sv
sim/tb_cartesian_to_polar.sv
